/* design/dhoa_pkg.sv */
// ----------------------------------------------------------------------------
// dhoa_pkg: shared types and constants for the digit hash insert core
// Widths, register indexes, controller states, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dhoa_pkg;

   localparam int MAX_SLOTS   = 2048;
   localparam int SLOT_W      = 11;            // slot_written field width
   localparam int SIZE_W      = 12;            // table_size, counts up to MAX_SLOTS
   localparam int HI_W        = 20;
   localparam int LO_W        = 24;
   localparam int DATA_W      = 32;
   localparam int KEY_W       = HI_W + LO_W;
   localparam int ENTRY_W     = 1 + KEY_W + DATA_W;
   localparam int COLL_W      = 32;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 72;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 12;
   localparam int DIV_W       = 11;            // hash sums and steps stay below 2048
   localparam int DIV_CNT_W   = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_HASH_MODE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_TABLE_SIZE = 1'b1;
   localparam logic [SIZE_W-1:0]      TABLE_SIZE_RESET = 12'd1280;
   localparam logic                   MODE_EXTRACT   = 1'b0;
   localparam logic [3:0]             DIGIT_MAX      = 4'd9;
   localparam logic [DIV_CNT_W-1:0]   DIV_STEPS      = DIV_CNT_W'(DIV_W);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_HOME_DIV,
      ST_STEP_DIV,
      ST_READ,
      ST_TEST,
      ST_WRITE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_in;
      logic clear_step;
      logic div_start_home;
      logic div_start_step;
      logic div_step;
      logic home_latch;
      logic step_latch;
      logic probe_hit;
      logic probe_free;
      logic write_slot;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic bad;
      logic div_done;
      logic slot_occupied;
      logic path_full;
      logic rsp_free;
   } sts_type;

endpackage

/* design/dhoa_ram.sv */
// ----------------------------------------------------------------------------
// dhoa_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dhoa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/dhoa_ctrl.sv */
// ----------------------------------------------------------------------------
// dhoa_ctrl: insert sequencer
// Clears the slot memory after reset. Each item: digit check; if good, two
// remainder passes, the probe loop and the slot write; then the result.
// ----------------------------------------------------------------------------
module dhoa_ctrl
   import dhoa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.bad) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_start_home = 1'b1;
               state_in           = ST_HOME_DIV;
            end
         end
         ST_HOME_DIV: begin
            if (sts.div_done) begin
               cmd.home_latch     = 1'b1;
               cmd.div_start_step = 1'b1;
               state_in           = ST_STEP_DIV;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_STEP_DIV: begin
            if (sts.div_done) begin
               cmd.step_latch = 1'b1;
               state_in       = ST_READ;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_READ: begin
            // wait for the registered slot read
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (!sts.slot_occupied) begin
               cmd.probe_free = 1'b1;
               state_in       = ST_WRITE;
            end else begin
               cmd.probe_hit = 1'b1;
               state_in      = sts.path_full ? ST_WRITE : ST_READ;
            end
         end
         ST_WRITE: begin
            cmd.write_slot = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the result register is free
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_write_never_bad: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> !sts.bad)
      else $error("slot write with a bad digit");

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_CHECK)
      else $error("accepted beat did not enter the digit check");

   a_free_slot_writes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TEST && !sts.slot_occupied |=> state_ff == ST_WRITE)
      else $error("free slot did not lead to a write");

endmodule

/* design/dhoa_datapath.sv */
// ----------------------------------------------------------------------------
// dhoa_datapath: registers, remainder unit, probe arithmetic and slot memory
// Holds configuration, the current item, a bit-serial remainder unit for the
// home slot and step, the probe index, counters and the result register.
// ----------------------------------------------------------------------------
module dhoa_datapath
   import dhoa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser
);

   // configuration
   logic              hash_mode_ff;
   logic [SIZE_W-1:0] table_size_ff;
   logic [SIZE_W-1:0] size_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_mode_ff  <= MODE_EXTRACT;
         table_size_ff <= TABLE_SIZE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_HASH_MODE:  hash_mode_ff  <= csr_data[0];
            REG_TABLE_SIZE: table_size_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (table_size_ff == '0) begin
         size_eff = SIZE_W'(1);
      end else if (table_size_ff > SIZE_W'(MAX_SLOTS)) begin
         size_eff = SIZE_W'(MAX_SLOTS);
      end else begin
         size_eff = table_size_ff;
      end
   end

   // item registers
   logic [HI_W-1:0]   hi_ff;
   logic [LO_W-1:0]   lo_ff;
   logic [DATA_W-1:0] payload_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         hi_ff      <= req_tdata[HI_W-1:0];
         lo_ff      <= req_tdata[KEY_W-1:HI_W];
         payload_ff <= req_tdata[KEY_W+DATA_W-1:KEY_W];
      end
   end

   // digits d1..d5 from hi_ff, d6..d11 from lo_ff, most significant first
   logic [3:0]       dg [1:11];
   logic             bad;
   logic [DIV_W-1:0] home_val;
   logic [DIV_W-1:0] step_val;

   always_comb begin
      for (int k = 0; k < 5; k++) begin
         dg[1+k] = hi_ff[4*(4-k) +: 4];
      end
      for (int k = 0; k < 6; k++) begin
         dg[6+k] = lo_ff[4*(5-k) +: 4];
      end
      bad = 1'b0;
      for (int k = 1; k <= 11; k++) begin
         if (dg[k] > DIGIT_MAX) begin
            bad = 1'b1;
         end
      end
      if (hash_mode_ff == MODE_EXTRACT) begin
         home_val = DIV_W'(dg[1]) * DIV_W'(100) + DIV_W'(dg[3]) * DIV_W'(10)
                  + DIV_W'(dg[4]);
         step_val = DIV_W'(dg[5]);
      end else begin
         home_val = DIV_W'(dg[6]) * DIV_W'(100) + DIV_W'(dg[7]) * DIV_W'(10)
                  + DIV_W'(dg[11])
                  + DIV_W'(dg[8]) * DIV_W'(100) + DIV_W'(dg[9]) * DIV_W'(10)
                  + DIV_W'(dg[10]);
         step_val = DIV_W'(dg[6]) + DIV_W'(dg[11]);
      end
   end

   // bit-serial remainder: one dividend bit per cycle
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [SLOT_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SIZE_W-1:0]    rem_sh;

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      rem_sh = {rem_ff, dvd_ff[DIV_W-1]};
      if (cmd.div_start_home || cmd.div_start_step) begin
         dvd_in = cmd.div_start_home ? home_val : step_val;
         rem_in = '0;
         cnt_in = DIV_STEPS;
      end else if (cmd.div_step) begin
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         rem_in = (rem_sh >= size_eff) ? SLOT_W'(rem_sh - size_eff) : SLOT_W'(rem_sh);
         cnt_in = cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   // probe state
   logic [SLOT_W-1:0] home_ff;
   logic [SLOT_W-1:0] stepm_ff;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SIZE_W-1:0] tries_ff, tries_in;
   logic              replaced_ff, replaced_in;
   logic [SIZE_W-1:0] idx_sum;
   logic [SLOT_W-1:0] idx_next;
   logic              path_full;

   assign idx_sum   = {1'b0, idx_ff} + {1'b0, stepm_ff};
   assign idx_next  = (idx_sum >= size_eff) ? SLOT_W'(idx_sum - size_eff) : SLOT_W'(idx_sum);
   assign path_full = ({1'b0, tries_ff} + (SIZE_W+1)'(1)) >= {1'b0, size_eff};

   always_comb begin
      idx_in      = idx_ff;
      tries_in    = tries_ff;
      replaced_in = replaced_ff;
      if (cmd.step_latch) begin
         idx_in      = home_ff;
         tries_in    = '0;
         replaced_in = 1'b0;
      end else if (cmd.probe_hit) begin
         tries_in = tries_ff + SIZE_W'(1);
         if (path_full) begin
            idx_in      = home_ff;
            replaced_in = 1'b1;
         end else begin
            idx_in = idx_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.home_latch) begin
         home_ff <= rem_ff;
      end
      if (cmd.step_latch) begin
         stepm_ff <= rem_ff;
      end
      idx_ff      <= idx_in;
      tries_ff    <= tries_in;
      replaced_ff <= replaced_in;
   end

   // counters
   logic [COLL_W-1:0] coll_ff, coll_in;
   logic [SIZE_W-1:0] occ_ff, occ_in;

   always_comb begin
      coll_in = coll_ff;
      occ_in  = occ_ff;
      if (cmd.probe_hit && coll_ff != '1) begin
         coll_in = coll_ff + COLL_W'(1);
      end
      if (cmd.probe_free) begin
         occ_in = occ_ff + SIZE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coll_ff <= '0;
         occ_ff  <= '0;
      end else begin
         coll_ff <= coll_in;
         occ_ff  <= occ_in;
      end
   end

   // slot memory: valid, key, payload; swept to zero after reset
   logic [SLOT_W-1:0]  clr_ff;
   logic [SLOT_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + SLOT_W'(1);
      end
   end

   assign wr_addr = cmd.clear_step ? clr_ff : idx_ff;
   assign wr_data = cmd.clear_step ? '0 : {1'b1, hi_ff, lo_ff, payload_ff};

   dhoa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.clear_step | cmd.write_slot),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // result register
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic                   rsp_bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_bad_ff <= bad;
         if (bad) begin
            rsp_data_ff <= {4'b0, occ_ff, coll_ff, 1'b0, SIZE_W'(0), SLOT_W'(0)};
         end else begin
            rsp_data_ff <= {4'b0, occ_ff, coll_ff, replaced_ff, tries_ff, idx_ff};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_bad_ff;

   assign sts.clear_last    = (clr_ff == SLOT_W'(MAX_SLOTS - 1));
   assign sts.bad           = bad;
   assign sts.div_done      = (cnt_ff == '0);
   assign sts.slot_occupied = rd_data[ENTRY_W-1];
   assign sts.path_full     = path_full;
   assign sts.rsp_free      = !rsp_valid_ff || rsp_tready;

   a_coll_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> coll_ff >= $past(coll_ff))
      else $error("collision count went down");

   a_occ_single_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> occ_ff == $past(occ_ff) || occ_ff == $past(occ_ff) + SIZE_W'(1))
      else $error("occupancy moved by more than one");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

endmodule

/* design/digit_hash_open_address_insert_core.sv */
// ----------------------------------------------------------------------------
// digit_hash_open_address_insert_core: open-addressed hash table insert
// Inserts keyed records into a table of up to 2048 slots, probing with a key-derived step.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one insert per beat: BCD ID digits and a 32-bit payload.
//   rsp_* returns one beat per insert: slot, occupied probes, home-replace
//   flag, running collision and occupancy counts; rsp_tuser flags a nibble
//   above 9, in which case nothing is inserted.
//   csr_* writes hash_mode (index 0) or table_size (index 1); csr_ready is
//   always high. Write only while no insert is in flight.
//   After reset the slot memory is swept clear, one slot a cycle, across all
//   2048 slots; req_tready stays low during the sweep.
//   A good insert runs two 11-bit serial remainder passes (home slot and
//   step), then probes through the registered slot memory read, a read
//   and a test state per probe; when every probe finds the slot occupied,
//   the home slot is replaced. A bad-digit beat skips straight to the
//   result. Inserts run one at a time.
//   The result register holds a beat while rsp_tready is low; the next beat
//   is still accepted and processed, then waits for the register to drain.
// ----------------------------------------------------------------------------
module digit_hash_open_address_insert_core
   import dhoa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [19:0] id_high_digits, [43:20] id_low_digits, [75:44] record_payload
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [10:0] slot_written, [22:11] probe_attempts, [23] replaced_home,
   // [55:24] collision_total, [67:56] occupied_count
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [0] bad_digit
   output logic                   rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   dhoa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dhoa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
